// File: src/sdpc_pkg.sv
// Shared types and constants for the stick deadzone and polar conversion block.
// Holds the payload structs, the CORDIC cell record and the arctangent table.
// Depends on nothing else.
package sdpc_pkg;

    localparam int XW        = 34;
    localparam int ZW        = 31;
    localparam int PRE_SHIFT = 14;
    localparam int ACC_FRAC  = 20;
    localparam int TABLE_LEN = 24;
    localparam int MW        = 31;
    localparam int IGW       = 30;
    localparam int PW        = MW + IGW;
    localparam int FSW       = 16;
    localparam int SPD_SH    = 15 + PRE_SHIFT;

    localparam logic [IGW-1:0]       INV_GAIN = 30'd652032874;
    localparam logic signed [ZW-1:0] Z180     = ZW'(180 * (1 << ACC_FRAC));

    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_FULL_SPEED = 1'b1;

    typedef struct packed {
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
    } t_in;

    typedef struct packed {
        logic               active;
        logic signed [15:0] direction;
        logic [16:0]        speed;
    } t_out;

    typedef struct packed {
        logic               valid;
        logic               active;
        logic               clr;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cell;

    function automatic logic signed [ZW-1:0] atan_q20(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = ZW'(47185920);
            1:       v = ZW'(27855475);
            2:       v = ZW'(14718068);
            3:       v = ZW'(7471121);
            4:       v = ZW'(3750058);
            5:       v = ZW'(1876857);
            6:       v = ZW'(938658);
            7:       v = ZW'(469357);
            8:       v = ZW'(234682);
            9:       v = ZW'(117342);
            10:      v = ZW'(58671);
            11:      v = ZW'(29335);
            12:      v = ZW'(14668);
            13:      v = ZW'(7334);
            14:      v = ZW'(3667);
            15:      v = ZW'(1833);
            16:      v = ZW'(917);
            17:      v = ZW'(458);
            18:      v = ZW'(229);
            19:      v = ZW'(115);
            20:      v = ZW'(57);
            21:      v = ZW'(29);
            22:      v = ZW'(14);
            23:      v = ZW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/sdpc_cell.sv
// One CORDIC vectoring cell: a single micro-rotation by atan(2^-IDX), registered.
// Uses the cell record and the arctangent table from sdpc_pkg.
module sdpc_cell
    import sdpc_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cell i_d,
    input  logic  i_ready,
    output logic  o_ready,
    output t_cell o_d
);

    localparam logic signed [ZW-1:0] ATAN = atan_q20(IDX);

    t_cell r_d;
    t_cell n_d;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    always_comb begin
        dx  = i_d.y >>> IDX;
        dy  = i_d.x >>> IDX;
        n_d = i_d;
        if (i_d.y[XW-1]) begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - ATAN;
        end else begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + ATAN;
        end
    end

    assign o_ready = !r_d.valid || i_ready;
    assign o_d     = r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (o_ready) begin
            r_d <= n_d;
        end
    end

endmodule

// File: src/sdpc_finish.sv
// Output pipeline: angle clamp and rounding, gain correction and speed scaling.
// Three stages with their own valid bits; the last one is the output register.
// Uses the types and constants of sdpc_pkg.
module sdpc_finish
    import sdpc_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cell          i_d,
    input  logic [FSW-1:0] i_full_speed,
    input  logic           i_stall,
    output logic           o_ready,
    output logic           o_valid,
    output t_out           o_out
);

    localparam int SH     = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int HALF_I = 1 << (SH - 1);
    localparam logic signed [ZW-1:0] HALF  = ZW'(HALF_I);
    localparam logic signed [ZW-1:0] D_MAX = ZW'(32767);
    localparam logic signed [ZW-1:0] D_MIN = -ZW'(32768);
    localparam logic [PW-1:0] RND = PW'(1) << (IGW - 1);

    logic               r_a_valid;
    logic               r_a_act;
    logic               r_a_clr;
    logic signed [15:0] r_a_dir;
    logic [PW-1:0]      r_a_prod;

    logic               r_b_valid;
    logic               r_b_act;
    logic               r_b_clr;
    logic signed [15:0] r_b_dir;
    logic [MW+FSW-1:0]  r_b_prod;

    t_out r_c;
    logic r_c_valid;

    logic rdy_a;
    logic rdy_b;
    logic rdy_c;

    logic signed [ZW-1:0] zc;
    logic signed [ZW-1:0] zr;
    logic signed [15:0]   dir;
    logic [MW-1:0]        xpos;
    logic [PW-1:0]        rsum;
    logic [MW-1:0]        mag;
    logic [MW+FSW-SPD_SH-1:0] spd;
    logic [16:0]          spd_sat;

    assign rdy_c   = !r_c_valid || !i_stall;
    assign rdy_b   = !r_b_valid || rdy_c;
    assign rdy_a   = !r_a_valid || rdy_b;
    assign o_ready = rdy_a;

    always_comb begin
        if (i_d.z > Z180) begin
            zc = Z180;
        end else if (i_d.z < -Z180) begin
            zc = -Z180;
        end else begin
            zc = i_d.z;
        end
        zr = (zc + HALF) >>> SH;
        if (zr > D_MAX) begin
            dir = 16'sh7fff;
        end else if (zr < D_MIN) begin
            dir = -16'sh8000;
        end else begin
            dir = zr[15:0];
        end
        if (!i_d.active || i_d.clr) begin
            dir = '0;
        end
        xpos = i_d.x[XW-1] ? '0 : i_d.x[MW-1:0];
    end

    always_comb begin
        rsum    = r_a_prod + RND;
        mag     = rsum[PW-1:IGW];
        spd     = r_b_prod[MW+FSW-1:SPD_SH];
        spd_sat = (spd > (MW+FSW-SPD_SH)'(131071)) ? 17'h1ffff : spd[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (rdy_a) begin
            r_a_valid <= i_d.valid;
            r_a_act   <= i_d.active;
            r_a_clr   <= i_d.clr;
            r_a_dir   <= dir;
            r_a_prod  <= PW'(xpos) * PW'(INV_GAIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (rdy_b) begin
            r_b_valid <= r_a_valid;
            r_b_act   <= r_a_act;
            r_b_clr   <= r_a_clr;
            r_b_dir   <= r_a_dir;
            r_b_prod  <= (MW+FSW)'(mag) * (MW+FSW)'(i_full_speed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (rdy_c) begin
            r_c_valid   <= r_b_valid;
            r_c.active  <= r_b_act;
            r_c.direction <= r_b_dir;
            r_c.speed   <= (!r_b_act || r_b_clr) ? '0 : spd_sat;
        end
    end

    assign o_valid = r_c_valid;
    assign o_out   = r_c;

endmodule

// File: src/stick_deadzone_polar_convert.sv
// Top level: deadzone test, half-plane fold, a chain of CORDIC cells and the output pipeline.
// Throughput is one transfer per cycle while i_stall is low; every cell and output stage
// has its own valid bit, so bubbles close up and a new sample is taken while a result
// waits at the output.
// Synchronous active-low reset empties the pipeline and sets both registers to defaults.
// Depends on sdpc_pkg, sdpc_cell and sdpc_finish.
module stick_deadzone_polar_convert
    import sdpc_pkg::*;
#(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_in,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [16:0] i_cfg_data
);

    localparam int DIR_RAW = 180 * (1 << ANGLE_FRAC_BITS);
    localparam int DIR_LIM = (DIR_RAW > 32767) ? 32767 : DIR_RAW;
    localparam int DIR_LO  = (DIR_RAW > 32768) ? -32768 : -DIR_RAW;

    logic [16:0]    r_threshold;
    logic [FSW-1:0] r_full_speed;

    t_cell r_pre;
    t_cell n_pre;
    logic  pre_ready;

    t_cell w_c   [0:CORDIC_STAGES];
    logic  w_rdy [0:CORDIC_STAGES];

    logic signed [16:0] sx17;
    logic signed [16:0] sy17;
    logic [16:0]        ax;
    logic [16:0]        ay;
    logic [17:0]        asum;
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= 17'd4096;
            r_full_speed <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THRESHOLD:  r_threshold  <= i_cfg_data;
                REG_FULL_SPEED: r_full_speed <= i_cfg_data[FSW-1:0];
                default:        r_threshold  <= r_threshold;
            endcase
        end
    end

    always_comb begin
        sx17 = {i_in.stick_x[15], i_in.stick_x};
        sy17 = {i_in.stick_y[15], i_in.stick_y};
        ax   = sx17[16] ? 17'(-sx17) : 17'(sx17);
        ay   = sy17[16] ? 17'(-sy17) : 17'(sy17);
        asum = {1'b0, ax} + {1'b0, ay};
        x0   = {{(XW-16-PRE_SHIFT){i_in.stick_x[15]}}, i_in.stick_x, {PRE_SHIFT{1'b0}}};
        y0   = {{(XW-16-PRE_SHIFT){i_in.stick_y[15]}}, i_in.stick_y, {PRE_SHIFT{1'b0}}};

        n_pre.valid  = i_valid;
        n_pre.active = asum >= {1'b0, r_threshold};
        n_pre.clr    = (i_in.stick_x == '0) && (i_in.stick_y == '0);
        if (i_in.stick_x[15]) begin
            n_pre.x = -x0;
            n_pre.y = -y0;
            n_pre.z = i_in.stick_y[15] ? -Z180 : Z180;
        end else begin
            n_pre.x = x0;
            n_pre.y = y0;
            n_pre.z = '0;
        end
    end

    assign pre_ready = !r_pre.valid || w_rdy[0];
    assign o_stall   = !pre_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.valid <= 1'b0;
        end else if (pre_ready) begin
            r_pre <= n_pre;
        end
    end

    assign w_c[0] = r_pre;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        sdpc_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_c[g]),
            .i_ready (w_rdy[g+1]),
            .o_ready (w_rdy[g]),
            .o_d     (w_c[g+1])
        );
    end

    sdpc_finish #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_finish (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_d          (w_c[CORDIC_STAGES]),
        .i_full_speed (r_full_speed),
        .i_stall      (i_stall),
        .o_ready      (w_rdy[CORDIC_STAGES]),
        .o_valid      (o_valid),
        .o_out        (o_out)
    );

    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.active) |-> (o_out.direction == '0 && o_out.speed == '0))
        else $error("inactive result carries a non-zero direction or speed");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while the output register is empty");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.direction <= DIR_LIM && o_out.direction >= DIR_LO))
        else $error("direction outside the half-turn range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

endmodule
